// ===== hw/rtl/fba_pkg.sv =====
// Shared types and constants of the frame bitmap allocator.
package fba_pkg;

	localparam int FRAME_W = 10;
	localparam int MODE_W  = 2;
	localparam int STAT_W  = 2;
	localparam int CNT_W   = 11;

	localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

	typedef enum logic [MODE_W-1:0] {
		MODE_ALLOC = 2'd0,
		MODE_MARK  = 2'd1,
		MODE_FREE  = 2'd2,
		MODE_TEST  = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_NONE_FREE = 2'd1,
		ST_NOT_ALLOC = 2'd2,
		ST_RANGE     = 2'd3
	} status_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		status_t            status;
		logic               was_used;
	} res_t;

endpackage

// ===== hw/rtl/fba_ifs.sv =====
// Request, response and configuration channels of the frame bitmap allocator.
interface fba_req_if import fba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [FRAME_W-1:0] frame_index;

	modport source (output valid, output mode, output frame_index, input ready);
	modport sink (input valid, input mode, input frame_index, output ready);
endinterface

interface fba_rsp_if import fba_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] result_frame;
	logic [STAT_W-1:0]  status;
	logic               was_used;

	modport source (output valid, output result_frame, output status, output was_used,
		input ready);
	modport sink (input valid, input result_frame, input status, input was_used,
		output ready);
endinterface

interface fba_cfg_if import fba_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] frame_count;

	modport source (output valid, output frame_count, input ready);
	modport sink (input valid, input frame_count, output ready);
endinterface

// ===== hw/rtl/fba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/fba_pick.sv =====
// Lowest clear bit of one bitmap word.
module fba_pick #(
	parameter int WORD_BITS = 32,
	localparam int OW = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] word,
	output logic                 found,
	output logic [OW-1:0]        pos
);

	always_comb begin
		found = 1'b0;
		pos   = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				found = 1'b1;
				pos   = OW'(i);
			end
		end
	end

endmodule

// ===== hw/rtl/fba_ctrl.sv =====
// Sequencer: clearing pass, first-fit word scan and read-modify-write of the bitmap.
module fba_ctrl import fba_pkg::*; #(
	parameter int NUM_FRAMES = 1024,
	parameter int WORD_BITS = 32,
	localparam int WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS,
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	fba_req_if.sink              req,
	input  logic [CNT_W-1:0]     eff_count,
	input  logic                 res_ready,
	output logic                 res_valid,
	output res_t                 res,
	output logic                 ram_we,
	output logic [AW-1:0]        ram_waddr,
	output logic [WORD_BITS-1:0] ram_wdata,
	output logic                 ram_re,
	output logic [AW-1:0]        ram_raddr,
	input  logic [WORD_BITS-1:0] ram_rdata
);

	localparam int OW = $clog2(WORD_BITS);
	// idx / WORD_BITS as a multiply by a rounded-up reciprocal, exact for 10-bit idx
	localparam int DIV_S = FRAME_W + OW;
	localparam int DIV_M = ((1 << DIV_S) + WORD_BITS - 1) / WORD_BITS;
	localparam int MW = FRAME_W + 1;
	localparam int PW = FRAME_W + MW;
	localparam int SPAN_W = $clog2(WORDS * WORD_BITS + 1);
	localparam int BW = (SPAN_W > CNT_W) ? SPAN_W : CNT_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_RDX,
		S_MODX,
		S_SCAN,
		S_RESULT
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      w_q;
	logic [BW-1:0]      base_q;
	mode_t              mode_q;
	logic [FRAME_W-1:0] idx_q;
	logic [FRAME_W-1:0] q_q;
	logic [OW-1:0]      r_q;
	res_t               res_q;

	logic               accept;
	mode_t              req_mode;
	logic               idx_oor;
	logic [PW-1:0]      div_prod;
	logic [FRAME_W-1:0] q_next;
	logic [FRAME_W-1:0] qwb;
	logic [OW-1:0]      r_next;
	logic [WORD_BITS-1:0] bit_m;
	logic               was;
	logic               pk_found;
	logic [OW-1:0]      pk_pos;
	logic [WORD_BITS-1:0] pk_mask;
	logic [BW-1:0]      scan_n;
	logic [BW-1:0]      scan_f;
	logic               scan_past;
	logic               scan_hit;
	logic               scan_last;
	logic               scan_fail;

	fba_pick #(.WORD_BITS(WORD_BITS)) u_pick (
		.word  (ram_rdata),
		.found (pk_found),
		.pos   (pk_pos)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign req_mode  = mode_t'(req.mode);
	assign idx_oor   = {1'b0, req.frame_index} >= eff_count;

	assign div_prod = PW'(req.frame_index) * PW'(DIV_M);
	assign q_next   = FRAME_W'(div_prod >> DIV_S);
	assign qwb      = q_q * FRAME_W'(WORD_BITS);
	assign r_next   = OW'(idx_q - qwb);

	assign bit_m   = {{(WORD_BITS - 1){1'b0}}, 1'b1} << r_q;
	assign was     = ram_rdata[r_q];
	assign pk_mask = {{(WORD_BITS - 1){1'b0}}, 1'b1} << pk_pos;

	assign scan_n    = BW'(eff_count);
	assign scan_f    = base_q + BW'(pk_pos);
	assign scan_past = base_q >= scan_n;
	assign scan_last = (w_q == AW'(WORDS - 1));
	assign scan_hit  = !scan_past && pk_found && (scan_f < scan_n);
	assign scan_fail = scan_past || (pk_found && !(scan_f < scan_n)) ||
		(!pk_found && scan_last);

	assign res_valid = (state_q == S_RESULT);
	assign res       = res_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = w_q;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_IDLE: begin
				ram_re = accept && (req_mode == MODE_ALLOC);
			end
			S_RDX: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(q_q);
			end
			S_MODX: begin
				ram_waddr = AW'(q_q);
				ram_we    = (mode_q == MODE_MARK) || (mode_q == MODE_FREE && was);
				ram_wdata = (mode_q == MODE_MARK) ? (ram_rdata | bit_m) : (ram_rdata & ~bit_m);
			end
			S_SCAN: begin
				// prefetch the next word while this one is examined
				ram_re    = 1'b1;
				ram_raddr = AW'(w_q + 1'b1);
				ram_we    = scan_hit;
				ram_wdata = ram_rdata | pk_mask;
			end
			S_RESULT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			w_q     <= '0;
			base_q  <= '0;
			mode_q  <= MODE_ALLOC;
			idx_q   <= '0;
			q_q     <= '0;
			r_q     <= '0;
			res_q   <= '{frame: '0, status: ST_OK, was_used: 1'b0};
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (scan_last) begin
						w_q     <= '0;
						state_q <= S_IDLE;
					end else begin
						w_q <= AW'(w_q + 1'b1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						mode_q <= req_mode;
						idx_q  <= req.frame_index;
						q_q    <= q_next;
						w_q    <= '0;
						base_q <= '0;
						if (req_mode == MODE_ALLOC) begin
							state_q <= S_SCAN;
						end else if (idx_oor) begin
							res_q   <= '{frame: req.frame_index, status: ST_RANGE, was_used: 1'b0};
							state_q <= S_RESULT;
						end else begin
							state_q <= S_RDX;
						end
					end
				end
				S_RDX: begin
					r_q     <= r_next;
					state_q <= S_MODX;
				end
				S_MODX: begin
					res_q.frame    <= idx_q;
					res_q.was_used <= was;
					res_q.status   <= (mode_q == MODE_FREE && !was) ? ST_NOT_ALLOC : ST_OK;
					state_q        <= S_RESULT;
				end
				S_SCAN: begin
					if (scan_hit) begin
						res_q   <= '{frame: FRAME_W'(scan_f), status: ST_OK, was_used: 1'b0};
						state_q <= S_RESULT;
					end else if (scan_fail) begin
						res_q   <= '{frame: '0, status: ST_NONE_FREE, was_used: 1'b0};
						state_q <= S_RESULT;
					end else begin
						w_q    <= AW'(w_q + 1'b1);
						base_q <= base_q + BW'(WORD_BITS);
					end
				end
				S_RESULT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_scan_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (w_q <= AW'(WORDS - 1)))
		else $error("scan word counter ran past the bitmap");

	a_alloc_sets_one_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && ram_we) |-> $onehot(ram_wdata ^ ram_rdata))
		else $error("allocate write changed other than one bit");

	a_free_clears_set_bit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MODX && ram_we && mode_q == MODE_FREE) |->
		(ram_rdata[r_q] && !ram_wdata[r_q]))
		else $error("free wrote a frame that was not set");

	a_alloc_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && mode_q == MODE_ALLOC && res_q.status == ST_OK) |->
		({1'b0, res_q.frame} < eff_count))
		else $error("allocated frame at or beyond frame count");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESULT && !res_ready) |=> (state_q == S_RESULT && $stable(res_q)))
		else $error("pending result lost before hand-off");
`endif

endmodule

// ===== hw/rtl/frame_bitmap_allocator.sv =====
// Allocate scans words in S_SCAN, 1..WORDS of them, then moves to S_RESULT ahead of the
// response register. Mark, free and test pass S_RDX, S_MODX and S_RESULT; an out-of-range
// index goes straight to S_RESULT. One item at a time; the allocate scan reads one word per
// cycle over the single bitmap RAM read port.
// After arst_n a clearing pass writes zero to all WORDS bitmap words; requests wait,
// configuration writes are taken throughout.
module frame_bitmap_allocator import fba_pkg::*; #(
	parameter int NUM_FRAMES = 1024,
	parameter int WORD_BITS = 32
) (
	input logic         clk,
	input logic         arst_n,
	fba_req_if.sink     req,
	fba_rsp_if.source   rsp,
	fba_cfg_if.sink     cfg
);

	localparam int WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
	localparam int AW = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam logic [CNT_W-1:0] EFF_RESET =
		(NUM_FRAMES < 32'(CNT_RESET)) ? CNT_W'(NUM_FRAMES) : CNT_RESET;

	logic [CNT_W-1:0]     eff_q;
	logic                 out_v_q;
	res_t                 out_q;

	logic                 res_valid;
	logic                 res_ready;
	res_t                 res;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	assign cfg.ready = 1'b1;

	// frame count is kept already saturated to NUM_FRAMES
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_q <= EFF_RESET;
		end else if (cfg.valid && cfg.ready) begin
			eff_q <= (32'(cfg.frame_count) > NUM_FRAMES) ? CNT_W'(NUM_FRAMES) : cfg.frame_count;
		end
	end

	assign res_ready = !out_v_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.result_frame = out_q.frame;
	assign rsp.status       = out_q.status;
	assign rsp.was_used     = out_q.was_used;

	fba_ctrl #(
		.NUM_FRAMES (NUM_FRAMES),
		.WORD_BITS  (WORD_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.eff_count (eff_q),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res       (res),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	fba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
